>>> hw/rtl/bns_pkg.sv
package bns_pkg;

    localparam int DEF_TABLE_SIDE = 64;

    localparam int COORD_W     = 24;
    localparam int FRAC_W      = 8;
    localparam int INT_W       = COORD_W - FRAC_W;
    localparam int ENTRY_IDX_W = 6;
    localparam int VALUE_W     = 16;

    // Magnitude of a floor integer or of its successor; 32768 still fits.
    localparam int MAG_W = INT_W;

    localparam int CORNERS = 4;

    // Index lanes of the wrap pipeline.
    localparam int LANE_U0 = 0;
    localparam int LANE_U1 = 1;
    localparam int LANE_V0 = 2;
    localparam int LANE_V1 = 3;

    // Corner order of the table reads.
    localparam int CORNER_A = 0;
    localparam int CORNER_B = 1;
    localparam int CORNER_C = 2;
    localparam int CORNER_D = 3;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

endpackage

>>> hw/rtl/bns_if.sv
interface bns_in_if;
    import bns_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
    logic [ENTRY_IDX_W-1:0]     entry_row;
    logic [ENTRY_IDX_W-1:0]     entry_col;
    logic [VALUE_W-1:0]         entry_value;

    modport source (
        output valid, command, coord_u, coord_v, entry_row, entry_col, entry_value,
        input  ready
    );

    modport sink (
        input  valid, command, coord_u, coord_v, entry_row, entry_col, entry_value,
        output ready
    );
endinterface

interface bns_out_if;
    import bns_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sample_value;

    modport source (
        output valid, sample_value,
        input  ready
    );

    modport sink (
        input  valid, sample_value,
        output ready
    );
endinterface

>>> hw/rtl/bns_table.sv
module bns_table #(
    parameter int TABLE_SIDE = bns_pkg::DEF_TABLE_SIDE,
    localparam int DEPTH     = TABLE_SIDE * TABLE_SIDE,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [bns_pkg::VALUE_W-1:0] wdata,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           raddr [bns_pkg::CORNERS],
    output logic [bns_pkg::VALUE_W-1:0] rdata [bns_pkg::CORNERS]
);
    import bns_pkg::*;

    // One copy of the table per corner, so all four corners are read in the same cycle.
    // Every write goes to all copies at once.
    for (genvar k = 0; k < CORNERS; k++)
    begin : g_copy
        logic [VALUE_W-1:0] table_mem [DEPTH];
        logic [VALUE_W-1:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                table_mem[waddr] <= wdata;
            end
            if (rd_en)
            begin
                rdata_reg <= table_mem[raddr[k]];
            end
        end

        assign rdata[k] = rdata_reg;
    end

endmodule

>>> hw/rtl/wrapped_bilinear_noise_sampler.sv
// Bilinear sampler over a TABLE_SIDE x TABLE_SIDE table of unsigned Q0.16 noise values.
// A write request stores one entry (ignored when the row or column is not below
// TABLE_SIDE) and gives no result; a sample request at signed Q16.8 coordinates gives one
// result, the blend of the four neighbors whose indices are the magnitude of the floor
// integer (and of its successor) taken modulo TABLE_SIDE. The block takes one request
// every cycle while the output is not stalled. A sample passes through seven register
// stages: the coordinate magnitudes, the index wrap (reciprocal multiply, correction,
// address), the table read and two blend stages. The table is replicated four times
// so the four corners are read in the same cycle; writes land in the fourth stage, so
// a sample sees every write requested before it. The table is not cleared at reset,
// and an entry that was never written reads as an undefined value.
module wrapped_bilinear_noise_sampler #(
    parameter int TABLE_SIDE = bns_pkg::DEF_TABLE_SIDE
) (
    input  logic       clk,
    input  logic       rst_n,
    bns_in_if.sink     req,
    bns_out_if.source  rsp
);
    import bns_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIDE);
    localparam int ADDR_W = $clog2(TABLE_SIDE * TABLE_SIDE);
    localparam int PROD_W = MAG_W + 32;
    localparam int REM_W  = MAG_W + 1;
    // floor(2^32 / TABLE_SIDE): quotient estimate is exact or one too small.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_SIDE);

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [INT_W:0] x);
        logic signed [INT_W:0] n;
        n = x[INT_W] ? -x : x;
        return n[MAG_W-1:0];
    endfunction

    // a + floor((b - a) * t / 256); stays between a and b.
    function automatic logic [VALUE_W-1:0] blend(
        input logic [VALUE_W-1:0] a,
        input logic [VALUE_W-1:0] b,
        input logic [FRAC_W-1:0]  t
    );
        logic signed [VALUE_W:0]          diff;
        logic signed [VALUE_W+FRAC_W+1:0] prod;
        logic signed [VALUE_W+FRAC_W+1:0] sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, t});
        sum  = $signed({{(FRAC_W + 2){1'b0}}, a}) + (prod >>> FRAC_W);
        return sum[VALUE_W-1:0];
    endfunction

    // Stage valid bits and the ready chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    // Stage 1: magnitudes, fractions, write request.
    logic [MAG_W-1:0]   mag1_reg [CORNERS];
    logic [MAG_W-1:0]   mag1_next [CORNERS];
    logic [FRAC_W-1:0]  fu1_reg, fv1_reg;
    cmd_t               cmd1_reg;
    logic               wen1_reg, wen1_next;
    logic [ADDR_W-1:0]  waddr1_reg, waddr1_next;
    logic [VALUE_W-1:0] wdata1_reg;
    logic signed [INT_W:0] iu_lo, iu_hi, iv_lo, iv_hi;

    // Stage 2: quotient estimates.
    logic [MAG_W-1:0]   mag2_reg [CORNERS];
    logic [MAG_W-1:0]   q2_reg [CORNERS];
    logic [MAG_W-1:0]   q2_next [CORNERS];
    logic [FRAC_W-1:0]  fu2_reg, fv2_reg;
    cmd_t               cmd2_reg;
    logic               wen2_reg;
    logic [ADDR_W-1:0]  waddr2_reg;
    logic [VALUE_W-1:0] wdata2_reg;

    // Stage 3: wrapped indices.
    logic [REM_W-1:0]   rem_raw [CORNERS];
    logic [IDX_W-1:0]   idx3_reg [CORNERS];
    logic [IDX_W-1:0]   idx3_next [CORNERS];
    logic [FRAC_W-1:0]  fu3_reg, fv3_reg;
    cmd_t               cmd3_reg;
    logic               wen3_reg;
    logic [ADDR_W-1:0]  waddr3_reg;
    logic [VALUE_W-1:0] wdata3_reg;

    // Stage 4: table addresses.
    logic [ADDR_W-1:0]  addr4_reg [CORNERS];
    logic [ADDR_W-1:0]  addr4_next [CORNERS];
    logic [FRAC_W-1:0]  fu4_reg, fv4_reg;
    cmd_t               cmd4_reg;
    logic               wen4_reg;
    logic [ADDR_W-1:0]  waddr4_reg;
    logic [VALUE_W-1:0] wdata4_reg;
    logic               sample4;

    // Stage 5: corner values (registered inside the table).
    logic [VALUE_W-1:0] corner5 [CORNERS];
    logic [FRAC_W-1:0]  fu5_reg, fv5_reg;
    logic               table_we;

    // Stage 6: blends along u.
    logic [VALUE_W-1:0] top6_reg, top6_next;
    logic [VALUE_W-1:0] bot6_reg, bot6_next;
    logic [FRAC_W-1:0]  fv6_reg;

    // Stage 7: output register.
    logic [VALUE_W-1:0] value7_reg, value7_next;

    assign sample4 = (cmd4_reg == CMD_SAMPLE);

    // Write requests leave the pipeline in stage 4, so they never wait on stage 5.
    assign rdy7 = !v7_reg || rsp.ready;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || !sample4 || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign req.ready        = rdy1;
    assign rsp.valid        = v7_reg;
    assign rsp.sample_value = value7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg && sample4;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // Stage 1 logic: floor integers by arithmetic shift, then magnitudes of i and i+1.
    always_comb
    begin
        iu_lo = $signed({req.coord_u[COORD_W-1], req.coord_u[COORD_W-1:FRAC_W]});
        iv_lo = $signed({req.coord_v[COORD_W-1], req.coord_v[COORD_W-1:FRAC_W]});
        iu_hi = iu_lo + (INT_W + 1)'(1);
        iv_hi = iv_lo + (INT_W + 1)'(1);
        mag1_next[LANE_U0] = magnitude(iu_lo);
        mag1_next[LANE_U1] = magnitude(iu_hi);
        mag1_next[LANE_V0] = magnitude(iv_lo);
        mag1_next[LANE_V1] = magnitude(iv_hi);
        wen1_next   = (int'(req.entry_row) < TABLE_SIDE) && (int'(req.entry_col) < TABLE_SIDE);
        waddr1_next = ADDR_W'(int'(req.entry_row) * TABLE_SIDE + int'(req.entry_col));
    end

    // Stage 2 logic: quotient estimate by reciprocal multiply.
    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            logic [PROD_W-1:0] prod;
            prod       = PROD_W'(mag1_reg[k]) * PROD_W'(RECIP);
            q2_next[k] = prod[PROD_W-1:32];
        end
    end

    // Stage 3 logic: remainder below twice the side, one correction step.
    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            rem_raw[k] = {1'b0, mag2_reg[k]} - REM_W'(int'(q2_reg[k]) * TABLE_SIDE);
            if (rem_raw[k] >= REM_W'(TABLE_SIDE))
            begin
                idx3_next[k] = IDX_W'(rem_raw[k] - REM_W'(TABLE_SIDE));
            end
            else
            begin
                idx3_next[k] = IDX_W'(rem_raw[k]);
            end
        end
    end

    // Stage 4 logic: row-major addresses of the four corners.
    always_comb
    begin
        addr4_next[CORNER_A] =
            ADDR_W'(int'(idx3_reg[LANE_U0]) * TABLE_SIDE + int'(idx3_reg[LANE_V0]));
        addr4_next[CORNER_B] =
            ADDR_W'(int'(idx3_reg[LANE_U1]) * TABLE_SIDE + int'(idx3_reg[LANE_V0]));
        addr4_next[CORNER_C] =
            ADDR_W'(int'(idx3_reg[LANE_U0]) * TABLE_SIDE + int'(idx3_reg[LANE_V1]));
        addr4_next[CORNER_D] =
            ADDR_W'(int'(idx3_reg[LANE_U1]) * TABLE_SIDE + int'(idx3_reg[LANE_V1]));
    end

    assign table_we = v4_reg && !sample4 && wen4_reg;

    bns_table #(
        .TABLE_SIDE (TABLE_SIDE)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (waddr4_reg),
        .wdata (wdata4_reg),
        .rd_en (rdy5),
        .raddr (addr4_reg),
        .rdata (corner5)
    );

    always_comb
    begin
        top6_next   = blend(corner5[CORNER_A], corner5[CORNER_B], fu5_reg);
        bot6_next   = blend(corner5[CORNER_C], corner5[CORNER_D], fu5_reg);
        value7_next = blend(top6_reg, bot6_reg, fv6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mag1_reg   <= mag1_next;
            fu1_reg    <= req.coord_u[FRAC_W-1:0];
            fv1_reg    <= req.coord_v[FRAC_W-1:0];
            cmd1_reg   <= cmd_t'(req.command);
            wen1_reg   <= wen1_next;
            waddr1_reg <= waddr1_next;
            wdata1_reg <= req.entry_value;
        end
        if (rdy2)
        begin
            mag2_reg   <= mag1_reg;
            q2_reg     <= q2_next;
            fu2_reg    <= fu1_reg;
            fv2_reg    <= fv1_reg;
            cmd2_reg   <= cmd1_reg;
            wen2_reg   <= wen1_reg;
            waddr2_reg <= waddr1_reg;
            wdata2_reg <= wdata1_reg;
        end
        if (rdy3)
        begin
            idx3_reg   <= idx3_next;
            fu3_reg    <= fu2_reg;
            fv3_reg    <= fv2_reg;
            cmd3_reg   <= cmd2_reg;
            wen3_reg   <= wen2_reg;
            waddr3_reg <= waddr2_reg;
            wdata3_reg <= wdata2_reg;
        end
        if (rdy4)
        begin
            addr4_reg  <= addr4_next;
            fu4_reg    <= fu3_reg;
            fv4_reg    <= fv3_reg;
            cmd4_reg   <= cmd3_reg;
            wen4_reg   <= wen3_reg;
            waddr4_reg <= waddr3_reg;
            wdata4_reg <= wdata3_reg;
        end
        if (rdy5)
        begin
            fu5_reg <= fu4_reg;
            fv5_reg <= fv4_reg;
        end
        if (rdy6)
        begin
            top6_reg <= top6_next;
            bot6_reg <= bot6_next;
            fv6_reg  <= fv5_reg;
        end
        if (rdy7)
        begin
            value7_reg <= value7_next;
        end
    end

    // The reciprocal estimate is never more than one quotient short.
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (rem_raw[LANE_U0] < REM_W'(2 * TABLE_SIDE))
                && (rem_raw[LANE_U1] < REM_W'(2 * TABLE_SIDE))
                && (rem_raw[LANE_V0] < REM_W'(2 * TABLE_SIDE))
                && (rem_raw[LANE_V1] < REM_W'(2 * TABLE_SIDE)))
        else $error("wrap remainder out of correction range");

    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && sample4 |-> (int'(addr4_reg[CORNER_A]) < TABLE_SIDE * TABLE_SIDE)
                           && (int'(addr4_reg[CORNER_D]) < TABLE_SIDE * TABLE_SIDE))
        else $error("corner address beyond the table");

    // The pipeline only refuses a request when a finished result is held up at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("request refused without an output stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && !rdy6 |=> v6_reg && $stable(top6_reg) && $stable(bot6_reg))
        else $error("blend stage lost its contents during a stall");

endmodule

>>> test/tb_wrapped_bilinear_noise_sampler.sv
`timescale 1ns / 1ps

module tb_wrapped_bilinear_noise_sampler;
    import bns_pkg::*;

    localparam int SIDE        = DEF_TABLE_SIDE;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int ITEM_TARGET = 1650;
    localparam int SEGMENT     = 150;

    logic clk;
    logic rst_n;

    bns_in_if  req_if ();
    bns_out_if rsp_if ();

    wrapped_bilinear_noise_sampler #(
        .TABLE_SIDE (SIDE)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the noise table and which entries hold a written value.
    logic [VALUE_W-1:0] noise_copy [SIDE][SIDE];
    bit                 entry_written [SIDE][SIDE];

    logic [VALUE_W-1:0] expected_samples [$];

    int  error_count;
    int  items_sent;
    int  idle_cycles;
    bit  source_idles;
    bit  sink_idles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int wrap_axis(input int i);
        int r;
        r = i % SIDE;
        if (r < 0)
            r = -r;
        return r;
    endfunction

    // An arithmetic shift by eight is the floor of a division by 256.
    function automatic int lerp_q8(input int a, input int b, input int t);
        return a + (((b - a) * t) >>> FRAC_W);
    endfunction

    function automatic logic [VALUE_W-1:0] predict_sample(
        input logic signed [COORD_W-1:0] u,
        input logic signed [COORD_W-1:0] v
    );
        int su;
        int sv;
        int iu;
        int iv;
        int r0;
        int r1;
        int c0;
        int c1;
        int top;
        int bot;
        su  = u;
        sv  = v;
        iu  = su >>> FRAC_W;
        iv  = sv >>> FRAC_W;
        r0  = wrap_axis(iu);
        r1  = wrap_axis(iu + 1);
        c0  = wrap_axis(iv);
        c1  = wrap_axis(iv + 1);
        top = lerp_q8(noise_copy[r0][c0], noise_copy[r1][c0], su & 8'hff);
        bot = lerp_q8(noise_copy[r0][c1], noise_copy[r1][c1], su & 8'hff);
        return VALUE_W'(lerp_q8(top, bot, sv & 8'hff));
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        int pick;
        int small_val;
        pick = $urandom_range(0, 3);
        case (pick)
            0: return COORD_W'($urandom);
            1:
            begin
                small_val = int'($urandom_range(0, 8191)) - 4096;
                return COORD_W'(small_val);
            end
            2:
            begin
                if ($urandom_range(0, 1) == 1)
                    return COORD_W'(8388607 - int'($urandom_range(0, 1023)));
                return COORD_W'(-8388608 + int'($urandom_range(0, 1023)));
            end
            default: return COORD_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Sends one request and updates the shadow state once it is accepted.
    task automatic send_request(
        input cmd_t                      cmd,
        input logic signed [COORD_W-1:0] u,
        input logic signed [COORD_W-1:0] v,
        input logic [ENTRY_IDX_W-1:0]    row,
        input logic [ENTRY_IDX_W-1:0]    col,
        input logic [VALUE_W-1:0]        value
    );
        int gap;
        gap = source_idles ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.coord_u     <= u;
        req_if.coord_v     <= v;
        req_if.entry_row   <= row;
        req_if.entry_col   <= col;
        req_if.entry_value <= value;
        do
            @(posedge clk);
        while (!req_if.ready);
        items_sent++;
        if (cmd == CMD_WRITE)
        begin
            noise_copy[row][col]    = value;
            entry_written[row][col] = 1'b1;
        end
        else
        begin
            expected_samples.push_back(predict_sample(u, v));
        end
    endtask

    task automatic write_entry(
        input logic [ENTRY_IDX_W-1:0] row,
        input logic [ENTRY_IDX_W-1:0] col,
        input logic [VALUE_W-1:0]     value
    );
        send_request(CMD_WRITE, COORD_W'($urandom), COORD_W'($urandom), row, col, value);
    endtask

    // Fills any never-written corner first so the sample only reads defined entries.
    task automatic sample_at(
        input logic signed [COORD_W-1:0] u,
        input logic signed [COORD_W-1:0] v
    );
        int su;
        int sv;
        int rows [2];
        int cols [2];
        su      = u;
        sv      = v;
        rows[0] = wrap_axis(su >>> FRAC_W);
        rows[1] = wrap_axis((su >>> FRAC_W) + 1);
        cols[0] = wrap_axis(sv >>> FRAC_W);
        cols[1] = wrap_axis((sv >>> FRAC_W) + 1);
        foreach (rows[i])
            foreach (cols[j])
                if (!entry_written[rows[i]][cols[j]])
                    write_entry(ENTRY_IDX_W'(rows[i]), ENTRY_IDX_W'(cols[j]),
                                VALUE_W'($urandom));
        send_request(CMD_SAMPLE, u, v, ENTRY_IDX_W'($urandom), ENTRY_IDX_W'($urandom),
                     VALUE_W'($urandom));
    endtask

    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() > 0)
            @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        // Opposite extremes on the corners make every blend along u span the full range.
        write_entry(0, 0, 16'h0000);
        write_entry(1, 0, 16'hffff);
        write_entry(0, 1, 16'hffff);
        write_entry(1, 1, 16'h0000);
        sample_at(0, 0);
        sample_at(255, 0);
        sample_at(0, 255);
        sample_at(255, 255);
        sample_at(128, 128);
        // Small negative coordinates mirror onto rows and columns one and zero.
        sample_at(-1, -1);
        sample_at(-256, -129);
        // Largest and smallest coordinates wrap across the table edge.
        write_entry(63, 63, 16'hffff);
        write_entry(0, 63, 16'h0000);
        write_entry(63, 0, 16'h8001);
        sample_at(24'sh7fffff, 24'sh7fffff);
        sample_at(-24'sh800000, -24'sh800000);
        sample_at(24'sh7fffff, -24'sh800000);
        // Write with all-ones coordinates, which the write must ignore.
        send_request(CMD_WRITE, -24'sd1, -24'sd1, 0, 0, 16'hffff);
        sample_at(0, 0);
        wait_results_drained();
    endtask

    // A sample right behind the write of one of its corners, with no gaps.
    task automatic test_write_read_hazard();
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        int su;
        int sv;
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        repeat (30)
        begin
            u  = random_coord();
            v  = random_coord();
            su = u;
            sv = v;
            sample_at(u, v);
            write_entry(ENTRY_IDX_W'(wrap_axis((su >>> FRAC_W) + 1)),
                        ENTRY_IDX_W'(wrap_axis(sv >>> FRAC_W)),
                        VALUE_W'($urandom));
            sample_at(u, v);
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int segment_start;
        int pick;
        while (items_sent < ITEM_TARGET)
        begin
            source_idles  = ($urandom_range(0, 2) != 0);
            sink_idles    = ($urandom_range(0, 2) != 0);
            segment_start = items_sent;
            while (items_sent - segment_start < SEGMENT && items_sent < ITEM_TARGET)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    sample_at(random_coord(), random_coord());
                else if (pick < 9)
                    write_entry(ENTRY_IDX_W'($urandom), ENTRY_IDX_W'($urandom),
                                VALUE_W'($urandom));
                else
                    write_entry(ENTRY_IDX_W'($urandom), ENTRY_IDX_W'($urandom),
                                $urandom_range(0, 1) ? 16'hffff : 16'h0000);
            end
            // The sender holds off until every pending sample has come back.
            wait_results_drained();
        end
    endtask

    // Result side: when sink_idles is set, ready may drop for a random number of cycles before each result.
    initial
    begin
        int stall;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = sink_idles ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
        end
    end

    always @(posedge clk)
    begin
        logic [VALUE_W-1:0] want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected sample_value %h with no sample pending",
                             rsp_if.sample_value);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (rsp_if.sample_value !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("sample_value mismatch: expected %h, got %h",
                                 want, rsp_if.sample_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        error_count  = 0;
        items_sent   = 0;
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        foreach (entry_written[i, j])
        begin
            entry_written[i][j] = 1'b0;
            noise_copy[i][j]    = '0;
        end
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.command     <= CMD_WRITE;
        req_if.coord_u     <= '0;
        req_if.coord_v     <= '0;
        req_if.entry_row   <= '0;
        req_if.entry_col   <= '0;
        req_if.entry_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_write_read_hazard();
        test_random_traffic();

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
